// ===== design/ticu_pkg.sv =====
// shared types, codes and helpers of the toy cpu instruction execute unit
package ticu_pkg;

    localparam int REG_COUNT  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int WORD_W     = 32;
    localparam int SEL_W      = 4;
    localparam int REG_IDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [WORD_W-1:0]     word_t;
    typedef logic [SEL_W-1:0]      reg_sel_t;
    typedef logic [1:0]            mode_t;
    typedef logic [7:0]            opcode_t;

    localparam mode_t MODE_NONE = 2'd0;
    localparam mode_t MODE_REG  = 2'd1;
    localparam mode_t MODE_IMM  = 2'd2;

    localparam opcode_t OP_ADD = 8'd0;
    localparam opcode_t OP_MOV = 8'd1;
    localparam opcode_t OP_HLT = 8'd2;
    localparam opcode_t OP_JMP = 8'd3;
    localparam opcode_t OP_JOZ = 8'd4;
    localparam opcode_t OP_OUT = 8'd5;

    localparam word_t PC_STEP = word_t'(4);

    typedef struct packed {
        logic [7:0]  command;
        logic [1:0]  mode_a;
        logic [1:0]  mode_b;
        logic [1:0]  mode_c;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] operand_c;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        out_valid;
        logic [7:0]  out_char;
        logic        write_valid;
        logic [3:0]  write_index;
        logic [31:0] write_value;
    } res_item_t;

    typedef struct packed {
        logic     en;
        reg_sel_t idx;
        data_t    value;
    } rf_write_t;

    function automatic logic reg_in_range(reg_sel_t sel);
        return {1'b0, sel} < (SEL_W + 1)'(REG_COUNT);
    endfunction

endpackage

// ===== design/ticu_regfile.sv =====
// register file with registered reads, write bypass and per-entry valid bits
module ticu_regfile
    import ticu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rd_en,
    input  reg_sel_t  rd_sel_a,
    input  reg_sel_t  rd_sel_b,
    output data_t     rd_data_a,
    output data_t     rd_data_b,
    input  rf_write_t wr
);

    data_t                mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    data_t                rd_a_reg;
    data_t                rd_b_reg;

    function automatic data_t read_port(reg_sel_t sel, rf_write_t w, logic ok, data_t stored);
        data_t val;
        val = '0;
        if (w.en && w.idx == sel)
        begin
            val = w.value;
        end
        else if (reg_in_range(sel) && ok)
        begin
            val = stored;
        end
        return val;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx[REG_IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx[REG_IDX_W-1:0]] <= wr.value;
        end
        if (rd_en)
        begin
            rd_a_reg <= read_port(rd_sel_a, wr, valid_reg[rd_sel_a[REG_IDX_W-1:0]],
                                  mem[rd_sel_a[REG_IDX_W-1:0]]);
            rd_b_reg <= read_port(rd_sel_b, wr, valid_reg[rd_sel_b[REG_IDX_W-1:0]],
                                  mem[rd_sel_b[REG_IDX_W-1:0]]);
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== design/ticu_exec.sv =====
// instruction decode, operand select, add and program counter update
module ticu_exec
    import ticu_pkg::*;
(
    input  cmd_item_t item,
    input  data_t     rd_data_a,
    input  data_t     rd_data_b,
    input  word_t     pc,
    input  logic      halt,
    output res_item_t result,
    output rf_write_t wr,
    output word_t     pc_next,
    output logic      halt_next
);

    data_t    va;
    data_t    vb;
    data_t    sum;
    word_t    pc_base;
    reg_sel_t sel_b;
    reg_sel_t sel_c;

    function automatic data_t operand(mode_t mode, logic [31:0] word, data_t reg_val);
        data_t val;
        val = '0;
        if (mode == MODE_REG)
        begin
            val = reg_val;
        end
        else if (mode == MODE_IMM)
        begin
            val = data_t'(word);
        end
        return val;
    endfunction

    assign va    = operand(item.mode_a, item.operand_a, rd_data_a);
    assign vb    = operand(item.mode_b, item.operand_b, rd_data_b);
    assign sum   = va + vb;
    assign sel_b = item.operand_b[SEL_W-1:0];
    assign sel_c = item.operand_c[SEL_W-1:0];

    always_comb
    begin
        wr        = '0;
        pc_base   = pc;
        halt_next = halt;
        result    = '0;
        unique case (item.command)
            OP_ADD:
            begin
                if (item.mode_c == MODE_REG && reg_in_range(sel_c))
                begin
                    wr.en    = 1'b1;
                    wr.idx   = sel_c;
                    wr.value = sum;
                end
            end
            OP_MOV:
            begin
                if (item.mode_b == MODE_REG && reg_in_range(sel_b))
                begin
                    wr.en    = 1'b1;
                    wr.idx   = sel_b;
                    wr.value = va;
                end
            end
            OP_HLT:
            begin
                halt_next = 1'b1;
            end
            OP_JMP:
            begin
                pc_base = word_t'(va);
            end
            OP_JOZ:
            begin
                if (va == '0)
                begin
                    pc_base = word_t'(vb);
                end
            end
            OP_OUT:
            begin
                result.out_valid = 1'b1;
                result.out_char  = 8'(va);
            end
            default:
            begin
            end
        endcase
        pc_next            = pc_base + PC_STEP;
        result.next_pc     = pc_next;
        result.halted      = halt_next;
        result.write_valid = wr.en;
        result.write_index = wr.idx;
        result.write_value = word_t'(wr.value);
    end

endmodule

// ===== design/toy_cpu_instruction_execute_unit.sv =====
// top level of the toy cpu instruction execute unit
// Executes one instruction per clock cycle at full rate: a command transaction is taken
// into an input register, together with the register file reads of operands a and b
// (registered, with bypass of the write made by the instruction ahead), and when it
// advances the decode, add and program counter logic place the result transaction in the
// output register and update the register file, pc and halt flag. A new command is taken
// every cycle unless the input register holds a command while the result register is
// full and not being taken.
// The register file comes out of reset all zero through per-entry valid bits, with no
// clearing pass.
module toy_cpu_instruction_execute_unit
    import ticu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    logic      in_valid_reg;
    cmd_item_t in_item_reg;
    logic      res_valid_reg;
    res_item_t res_data_reg;
    word_t     pc_reg;
    logic      halt_reg;

    logic      advance;
    logic      cmd_take;
    data_t     rd_data_a;
    data_t     rd_data_b;
    res_item_t result;
    rf_write_t wr_req;
    rf_write_t wr_gated;
    word_t     pc_next;
    logic      halt_next;

    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;
    assign cmd_take  = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_gated    = wr_req;
        wr_gated.en = wr_req.en && advance;
    end

    ticu_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (cmd_take),
        .rd_sel_a  (cmd_data.operand_a[SEL_W-1:0]),
        .rd_sel_b  (cmd_data.operand_b[SEL_W-1:0]),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr        (wr_gated)
    );

    ticu_exec u_exec (
        .item      (in_item_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .pc        (pc_reg),
        .halt      (halt_reg),
        .result    (result),
        .wr        (wr_req),
        .pc_next   (pc_next),
        .halt_next (halt_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                pc_reg        <= pc_next;
                halt_reg      <= halt_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_item_reg <= cmd_data;
        end
        if (advance)
        begin
            res_data_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    a_pc_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_data_reg.next_pc == pc_reg)
        else $error("pc differs from last result");

    a_halt_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_data_reg.halted == halt_reg)
        else $error("halt flag differs from last result");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.write_valid)
            |-> reg_in_range(res_data_reg.write_index))
        else $error("write to register outside the file");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (in_valid_reg && res_valid_reg && !res_ready))
        else $error("command stalled without a full pipeline");
`endif

endmodule
